// ===== src/swpe_pkg.sv =====
// Package for the word program executor: opcodes, queue entry type, sizes.
// No dependencies.
package swpe_pkg;

  localparam int WORD_W = 64;
  localparam int SLOT_W = 8;
  localparam int OP_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_CONST = 5'd0,  OP_INV  = 5'd1,  OP_INT  = 5'd2,  OP_AND  = 5'd3,
    OP_OR    = 5'd4,  OP_XOR  = 5'd5,  OP_ADD  = 5'd6,  OP_SUB  = 5'd7,
    OP_MUL   = 5'd8,  OP_SHL  = 5'd9,  OP_SHR  = 5'd10, OP_SAR  = 5'd11,
    OP_NOT   = 5'd12, OP_NEG  = 5'd13, OP_ULT  = 5'd14, OP_SLT  = 5'd15,
    OP_EQ    = 5'd16, OP_NEZ  = 5'd17, OP_SEL  = 5'd18, OP_POP  = 5'd19,
    OP_CLZ   = 5'd20, OP_UDIV = 5'd21, OP_UREM = 5'd22, OP_SDIV = 5'd23,
    OP_SREM  = 5'd24, OP_MULHI = 5'd25
  } opcode_t;

  // Classified step handed from front to back
  typedef struct packed {
    logic              execute;
    logic [OP_W-1:0]   opcode;
    logic [SLOT_W-1:0] dest;
    logic [SLOT_W-1:0] a_index;
    logic              a_used;
    logic [SLOT_W-1:0] b_index;
    logic              b_used;
    logic [SLOT_W-1:0] c_index;
    logic              c_used;
    logic [WORD_W-1:0] imm;
  } step_t;

endpackage

// ===== src/swpe_if.sv =====
// Stream interfaces for input steps and results.
// No dependencies.
interface swpe_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [4:0]                opcode;
  logic [7:0]                dest;
  logic [7:0]                a_index;
  logic                      a_used;
  logic [7:0]                b_index;
  logic                      b_used;
  logic [7:0]                c_index;
  logic                      c_used;
  logic [63:0]               imm;
  modport source (output valid, mode, opcode, dest, a_index, a_used, b_index, b_used,
                  c_index, c_used, imm, input ready);
  modport sink   (input valid, mode, opcode, dest, a_index, a_used, b_index, b_used,
                  c_index, c_used, imm, output ready);
endinterface

interface swpe_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  node;
  logic [63:0] result;
  modport source (output valid, node, result, input ready);
  modport sink   (input valid, node, result, output ready);
endinterface

// ===== src/swpe_front.sv =====
// Front end: takes input transfers into a two-entry step queue.
// Depends on swpe_pkg.
module swpe_front (
  input  logic            clk,
  input  logic            rst,
  swpe_in_if.sink         in,
  output swpe_pkg::step_t q_data,
  output logic            q_valid,
  input  logic            q_pop
);
  import swpe_pkg::*;

  step_t      mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in.ready = (count != 2'd2);
  assign push     = in.valid && in.ready;
  assign q_valid  = (count != 2'd0);
  assign q_data   = mem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{execute: in.mode, opcode: in.opcode, dest: in.dest,
                       a_index: in.a_index, a_used: in.a_used,
                       b_index: in.b_index, b_used: in.b_used,
                       c_index: in.c_index, c_used: in.c_used, imm: in.imm};
    end
  end

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ===== src/swpe_div.sv =====
// Iterative unsigned 64-bit divider, one quotient bit per cycle.
// Depends on swpe_pkg.
module swpe_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [63:0] rem
);
  import swpe_pkg::*;

  logic [63:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;
  logic [64:0] shifted;

  assign shifted = {rem, quot[63]};
  assign trial   = shifted - {1'b0, dvs};

  // Restoring division
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (!trial[64]) begin
        rem  <= trial[63:0];
        quot <= {quot[62:0], 1'b1};
      end else begin
        rem  <= shifted[63:0];
        quot <= {quot[62:0], 1'b0};
      end
    end
  end
endmodule

// ===== src/swpe_back.sv =====
// Back end: node store, operand fetch, ALU, divider and multiplier sequencing.
// Depends on swpe_pkg, swpe_div.
module swpe_back #(
  parameter int NODES = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  swpe_pkg::step_t q_data,
  input  logic            q_valid,
  output logic            q_pop,
  swpe_out_if.source      out
);
  import swpe_pkg::*;

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  // Reciprocal of NODES scaled by 2^16; exact slot folding for 8-bit indexes
  localparam logic [23:0] RECIP   = 24'((65536 + NODES - 1) / NODES);
  localparam logic [19:0] NODES_W = 20'(NODES);

  typedef enum logic [7:0] {
    S_CLR  = 8'b00000001, S_FETCH = 8'b00000010, S_READ = 8'b00000100,
    S_EXEC = 8'b00001000, S_MUL   = 8'b00010000, S_DIV  = 8'b00100000,
    S_FIX  = 8'b01000000, S_OUT   = 8'b10000000
  } state_t;

  state_t state;
  step_t  cur;
  logic [WORD_W-1:0] mem [NODES];
  logic [WORD_W-1:0] ra, rb, rc, rd;
  logic [WORD_W-1:0] a, b, res, alu;
  logic              cond;
  logic [AW-1:0]     p0, p1, wi, clr_idx;
  logic [63:0]       pll, plh, phl, phh;
  logic [WORD_W-1:0] ma, mb;
  logic              dstart, ddone;
  logic [63:0]       dq, dr;
  logic              wr_en;
  logic [6:0]        pc, lz;
  logic [3:0]        pcb [8];

  // Slot index modulo NODES by reciprocal multiplication
  function automatic logic [AW-1:0] slot(input logic [7:0] x);
    logic [23:0] prod;
    logic [7:0]  quo;
    logic [19:0] back;
    logic [7:0]  r;
    prod = {16'd0, x} * RECIP;
    quo  = prod[23:16];
    back = {12'd0, quo} * NODES_W;
    r    = x - back[7:0];
    if (NODES >= 256) return AW'(x);
    return AW'(r);
  endfunction

  assign wi = slot(cur.dest);

  // Two read ports: a and b in the fetch state, c and dest in the read state after it
  assign p0 = (state == S_FETCH) ? slot(q_data.a_index) : slot(cur.c_index);
  assign p1 = (state == S_FETCH) ? slot(q_data.b_index) : wi;

  // Store: registered reads, one write port shared with the clearing pass
  always_ff @(posedge clk) begin
    if (state == S_FETCH) begin
      ra <= mem[p0];
      rb <= mem[p1];
    end
    if (state == S_READ) begin
      rc <= mem[p0];
      rd <= mem[p1];
    end
    if (state == S_CLR) mem[clr_idx] <= '0;
    else if (wr_en) mem[wi] <= res;
  end

  assign a    = cur.a_used ? ra : '0;
  assign b    = cur.b_used ? rb : '0;
  assign cond = cur.c_used && (rc != '0);
  assign ma   = cur.a_used ? a : '0;
  assign mb   = b;

  // Popcount per byte then summed; leading zeros
  always_comb begin
    pc = '0;
    lz = 7'd64;
    for (int j = 0; j < 8; j++) begin
      pcb[j] = '0;
      for (int k = 0; k < 8; k++) pcb[j] = pcb[j] + {3'd0, a[8*j+k]};
    end
    for (int j = 0; j < 8; j++) pc = pc + {3'd0, pcb[j]};
    for (int i = 0; i < 64; i++) begin
      if (a[i]) lz = 7'(63 - i);
    end
  end

  // Combinational ALU operations
  always_comb begin
    case (cur.opcode)
      OP_CONST: alu = cur.imm;
      OP_INV, OP_INT: alu = rd;
      OP_AND:  alu = a & b;
      OP_OR:   alu = a | b;
      OP_XOR:  alu = a ^ b;
      OP_ADD:  alu = a + b;
      OP_SUB:  alu = a - b;
      OP_SHL:  alu = (b[63:6] == '0) ? (a << b[5:0]) : '0;
      OP_SHR:  alu = (b[63:6] == '0) ? (a >> b[5:0]) : '0;
      OP_SAR:  alu = (b[63:6] == '0) ? WORD_W'($signed(a) >>> b[5:0]) : {64{a[63]}};
      OP_NOT:  alu = ~a;
      OP_NEG:  alu = '0 - a;
      OP_ULT:  alu = {63'd0, a < b};
      OP_SLT:  alu = {63'd0, $signed(a) < $signed(b)};
      OP_EQ:   alu = {63'd0, a == b};
      OP_NEZ:  alu = {63'd0, a != '0};
      OP_SEL:  alu = cond ? a : b;
      OP_POP:  alu = {57'd0, pc};
      OP_CLZ:  alu = {57'd0, lz};
      default: alu = '0;
    endcase
  end

  wire is_mul = cur.execute && (cur.opcode == OP_MUL || cur.opcode == OP_MULHI);
  wire is_div = cur.execute && (cur.opcode == OP_UDIV || cur.opcode == OP_UREM ||
                                cur.opcode == OP_SDIV || cur.opcode == OP_SREM);
  wire is_sgn = (cur.opcode == OP_SDIV || cur.opcode == OP_SREM);

  logic [63:0] mag_a, mag_b;
  assign mag_a = (is_sgn && a[63]) ? '0 - a : a;
  assign mag_b = (is_sgn && b[63]) ? '0 - b : b;
  assign dstart = (state == S_EXEC) && is_div && (b != '0);

  swpe_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(mag_a), .divisor(mag_b),
    .done(ddone), .quot(dq), .rem(dr)
  );

  // Mul combine from registered 32x32 partial products
  logic [63:0] mid, mlo, mhi;
  assign mid = {32'd0, pll[63:32]} + {32'd0, plh[31:0]} + {32'd0, phl[31:0]};
  assign mlo = {mid[31:0], pll[31:0]};
  assign mhi = phh + {32'd0, plh[63:32]} + {32'd0, phl[63:32]} + {32'd0, mid[63:32]};

  assign q_pop = (state == S_FETCH) && q_valid;
  assign wr_en = (state == S_FIX);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      out.valid <= 1'b0;
      clr_idx   <= '0;
    end else begin
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(NODES - 1)) state <= S_FETCH;
        end
        S_FETCH: if (q_valid) state <= S_READ;
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          if (!cur.execute) begin
            res <= cur.imm; state <= S_FIX;
          end else if (is_mul) state <= S_MUL;
          else if (is_div && b != '0) state <= S_DIV;
          else begin
            res <= alu; state <= S_FIX;
          end
        end
        S_MUL: begin
          res   <= (cur.opcode == OP_MUL) ? mlo : mhi;
          state <= S_FIX;
        end
        S_DIV: if (ddone) begin
          case (cur.opcode)
            OP_UDIV: res <= dq;
            OP_UREM: res <= dr;
            OP_SDIV: res <= (a[63] ^ b[63]) ? '0 - dq : dq;
            default: res <= a[63] ? '0 - dr : dr;
          endcase
          state <= S_FIX;
        end
        S_FIX: begin
          out.valid  <= 1'b1;
          state      <= S_OUT;
        end
        S_OUT: if (out.ready) begin
          out.valid <= 1'b0;
          state     <= S_FETCH;
        end
        default: state <= S_FETCH;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
    if (state == S_EXEC) begin
      pll <= ma[31:0] * mb[31:0];
      plh <= ma[31:0] * mb[63:32];
      phl <= ma[63:32] * mb[31:0];
      phh <= ma[63:32] * mb[63:32];
    end
    if (state == S_FIX) begin
      out.node   <= cur.dest;
      out.result <= res;
    end
  end
endmodule

// ===== src/ssa_word_program_executor_top.sv =====
// Word program executor: store of NODES 64-bit nodes, one step per transfer.
// Steps pass one at a time through the back end sequencer: fetch, second store
// read, execute (with a multiply or divide state where needed), write, result hold;
// the next step is fetched only after the result has been taken.
// Synchronous active-high reset, then a clearing pass zeroes all NODES nodes of the
// store; steps wait in the queue until it ends. Depends on swpe_pkg, swpe_if,
// swpe_front, swpe_back.
module ssa_word_program_executor_top #(
  parameter int NODES = 256
) (
  input  logic clk,
  input  logic rst,
  swpe_in_if.sink    in,
  swpe_out_if.source out
);
  import swpe_pkg::*;

  step_t q_data;
  logic  q_valid, q_pop;

  swpe_front u_front (
    .clk(clk), .rst(rst), .in(in), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
  );

  swpe_back #(.NODES(NODES)) u_back (
    .clk(clk), .rst(rst), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop), .out(out)
  );
endmodule

// ===== src/swpe_checker.sv =====
// Port-level checker for the executor, bound to the top level.
// Depends on the top level's ports only.
module swpe_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_node,
  input logic [63:0] out_result
);
  // Result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_node))
    else $error("result changed while stalled");

  // No result straight out of reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result after reset");

  // Results never come on consecutive cycles after a transfer
  a_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid)
    else $error("back-to-back results");

  // Queue has room right after reset
  a_room: assert property (@(posedge clk) $past(rst) && !rst |-> in_ready)
    else $error("not ready after reset");
endmodule

bind ssa_word_program_executor_top swpe_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready), .out_node(out.node),
  .out_result(out.result)
);

// ===== dv/ssa_word_program_executor_top_test.sv =====
`timescale 1ns / 100ps
// Testbench for the word program executor: directed table then random programs.
// Depends on swpe_pkg, swpe_if and the executor RTL.
module ssa_word_program_executor_top_test;
  import swpe_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_STEPS   = 1500;

  typedef struct {
    logic              mode;
    opcode_t           op;
    logic [7:0]        dest;
    logic [7:0]        ai;
    logic              au;
    logic [7:0]        bi;
    logic              bu;
    logic [7:0]        ci;
    logic              cu;
    logic [63:0]       imm;
    logic              known;
    logic [63:0]       want;
  } step_row_t;

  typedef struct {
    logic [7:0]  node;
    logic [63:0] value;
  } written_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  swpe_in_if  in_ch ();
  swpe_out_if out_ch ();

  ssa_word_program_executor_top dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch.sink),
    .out (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [63:0] slot_mirror [256];
  written_t    pending_writes [$];
  int          error_count = 0;
  int          checked = 0;
  int          stalled_cycles = 0;
  bit          calm = 1'b0;
  step_row_t   table_rows [$];

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  function automatic logic [63:0] pop_count(input logic [63:0] v);
    logic [63:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) n += {63'd0, v[i]};
    return n;
  endfunction

  function automatic logic [63:0] zeros_above(input logic [63:0] v);
    for (int i = 63; i >= 0; i--) if (v[i]) return 64'(63 - i);
    return 64'd64;
  endfunction

  // Predicts the value written by one step and updates the mirror
  function automatic logic [63:0] execute_step(input step_row_t s);
    logic [63:0]  a, b, r, ma, mb, q, rm;
    logic [127:0] wide;
    logic         sel;
    a   = s.au ? slot_mirror[s.ai] : 64'd0;
    b   = s.bu ? slot_mirror[s.bi] : 64'd0;
    sel = s.cu && (slot_mirror[s.ci] != 0);
    ma  = a[63] ? -a : a;
    mb  = b[63] ? -b : b;
    q   = (mb != 0) ? ma / mb : 64'd0;
    rm  = (mb != 0) ? ma % mb : 64'd0;
    wide = {64'd0, a} * {64'd0, b};
    if (!s.mode) r = s.imm;
    else begin
      case (s.op)
        OP_CONST: r = s.imm;
        OP_INV, OP_INT: r = slot_mirror[s.dest];
        OP_AND: r = a & b;
        OP_OR: r = a | b;
        OP_XOR: r = a ^ b;
        OP_ADD: r = a + b;
        OP_SUB: r = a - b;
        OP_MUL: r = wide[63:0];
        OP_SHL: r = (b < 64) ? a << b[5:0] : 64'd0;
        OP_SHR: r = (b < 64) ? a >> b[5:0] : 64'd0;
        OP_SAR: r = (b < 64) ? 64'($signed(a) >>> b[5:0]) : {64{a[63]}};
        OP_NOT: r = ~a;
        OP_NEG: r = -a;
        OP_ULT: r = {63'd0, a < b};
        OP_SLT: r = {63'd0, $signed(a) < $signed(b)};
        OP_EQ: r = {63'd0, a == b};
        OP_NEZ: r = {63'd0, a != 0};
        OP_SEL: r = sel ? a : b;
        OP_POP: r = pop_count(a);
        OP_CLZ: r = zeros_above(a);
        OP_UDIV: r = (b != 0) ? a / b : 64'd0;
        OP_UREM: r = (b != 0) ? a % b : 64'd0;
        OP_SDIV: r = (b == 0) ? 64'd0 : ((a[63] ^ b[63]) ? -q : q);
        OP_SREM: r = (b == 0) ? 64'd0 : (a[63] ? -rm : rm);
        OP_MULHI: r = wide[127:64];
        default: r = 64'd0;
      endcase
    end
    slot_mirror[s.dest] = r;
    return r;
  endfunction

  function automatic step_row_t mk(input logic mode, input opcode_t op, input int dest,
                                   input int ai, input int bi, input logic [63:0] imm,
                                   input logic known, input logic [63:0] want);
    step_row_t s;
    s.mode = mode; s.op = op; s.dest = 8'(dest);
    s.ai = 8'(ai); s.au = 1'b1; s.bi = 8'(bi); s.bu = 1'b1;
    s.ci = 8'd0; s.cu = 1'b0; s.imm = imm; s.known = known; s.want = want;
    return s;
  endfunction

  // Random steps, undefined opcodes included, mostly read slots written near the same range
  function automatic step_row_t random_step();
    step_row_t s;
    s.mode = ($urandom_range(0, 9) != 0);
    s.op   = opcode_t'($urandom_range(0, 31));
    if ($urandom_range(0, 3) == 0) s.op = opcode_t'($urandom_range(OP_UDIV, OP_SREM));
    s.dest = 8'($urandom_range(0, 3) ? $urandom_range(0, 15) : $urandom_range(0, 255));
    s.ai   = 8'($urandom_range(0, 3) ? $urandom_range(0, 15) : $urandom_range(0, 255));
    s.bi   = 8'($urandom_range(0, 3) ? $urandom_range(0, 15) : $urandom_range(0, 255));
    s.ci   = 8'($urandom_range(0, 3) ? $urandom_range(0, 15) : $urandom_range(0, 255));
    s.au   = $urandom_range(0, 7) != 0;
    s.bu   = $urandom_range(0, 7) != 0;
    s.cu   = $urandom_range(0, 3) != 0;
    case ($urandom_range(0, 5))
      0: s.imm = {$urandom, $urandom};
      1: s.imm = 64'($urandom_range(0, 70));
      2: s.imm = 64'h8000_0000_0000_0000;
      3: s.imm = '1;
      default: s.imm = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    s.known = 1'b0; s.want = '0;
    return s;
  endfunction

  // Sends one step with random idling before it
  task automatic send_step(input step_row_t s);
    written_t w;
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= s.mode;
    in_ch.opcode  <= s.op;
    in_ch.dest    <= s.dest;
    in_ch.a_index <= s.ai;
    in_ch.a_used  <= s.au;
    in_ch.b_index <= s.bi;
    in_ch.b_used  <= s.bu;
    in_ch.c_index <= s.ci;
    in_ch.c_used  <= s.cu;
    in_ch.imm     <= s.imm;
    do @(posedge clk); while (!in_ch.ready);
    w.node  = s.dest;
    w.value = execute_step(s);
    if (s.known && w.value != s.want)
      report($sformatf("table row expects %h, predictor gives %h", s.want, w.value));
    pending_writes.push_back(w);
  endtask

  // Result sink with random stall
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm || ($urandom_range(0, 99) >= 32);
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    written_t w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_writes.size() == 0) report("result with nothing expected");
      else begin
        w = pending_writes.pop_front();
        if (out_ch.node !== w.node)
          report($sformatf("node %0d, expected %0d", out_ch.node, w.node));
        if (out_ch.result !== w.value)
          report($sformatf("node %0d result %h, expected %h", w.node, out_ch.result,
                           w.value));
        checked++;
      end
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stalled_cycles <= 0;
    else if (!rst) stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  localparam logic [63:0] MINW = 64'h8000_0000_0000_0000;

  initial begin
    in_ch.valid = 1'b0; in_ch.mode = 1'b0; in_ch.opcode = '0; in_ch.dest = '0;
    in_ch.a_index = '0; in_ch.a_used = 1'b0; in_ch.b_index = '0; in_ch.b_used = 1'b0;
    in_ch.c_index = '0; in_ch.c_used = 1'b0; in_ch.imm = '0;
    foreach (slot_mirror[i]) slot_mirror[i] = 64'd0;
    // Directed table: reset contents, extremes and special cases
    table_rows.push_back(mk(1, OP_ADD, 255, 0, 255, 0, 1, 64'd0));
    table_rows.push_back(mk(0, OP_CONST, 1, 0, 0, MINW, 1, MINW));
    table_rows.push_back(mk(0, OP_CONST, 2, 0, 0, '1, 1, '1));
    table_rows.push_back(mk(0, OP_CONST, 3, 0, 0, 64'd64, 1, 64'd64));
    table_rows.push_back(mk(1, OP_SDIV, 4, 1, 2, 0, 1, MINW));
    table_rows.push_back(mk(1, OP_SREM, 5, 1, 2, 0, 1, 64'd0));
    table_rows.push_back(mk(1, OP_UDIV, 6, 2, 0, 0, 1, 64'd0));
    table_rows.push_back(mk(1, OP_SREM, 6, 2, 0, 0, 1, 64'd0));
    table_rows.push_back(mk(1, OP_SHL, 7, 2, 3, 0, 1, 64'd0));
    table_rows.push_back(mk(1, OP_SHR, 7, 2, 3, 0, 1, 64'd0));
    table_rows.push_back(mk(1, OP_SAR, 8, 1, 3, 0, 1, '1));
    table_rows.push_back(mk(1, OP_CLZ, 9, 0, 0, 0, 1, 64'd64));
    table_rows.push_back(mk(1, OP_POP, 9, 2, 0, 0, 1, 64'd64));
    table_rows.push_back(mk(1, OP_CONST, 10, 0, 0, 64'h0123_4567_89ab_cdef, 1,
                            64'h0123_4567_89ab_cdef));
    table_rows.push_back(mk(1, OP_INV, 10, 0, 0, 0, 1, 64'h0123_4567_89ab_cdef));
    table_rows.push_back(mk(1, OP_INT, 10, 0, 0, 0, 1, 64'h0123_4567_89ab_cdef));
    table_rows.push_back(mk(1, opcode_t'(5'd31), 10, 2, 2, '1, 1, 64'd0));
    table_rows.push_back(mk(1, OP_SLT, 11, 1, 2, 0, 1, 64'd1));
    table_rows.push_back(mk(1, OP_ULT, 11, 1, 2, 0, 0, 0));
    table_rows.push_back(mk(1, OP_MULHI, 12, 2, 2, 0, 0, 0));
    table_rows.push_back(mk(1, OP_MUL, 12, 2, 2, 0, 0, 0));
    table_rows.push_back(mk(1, OP_SEL, 13, 2, 1, 0, 1, MINW));
    table_rows.push_back(mk(1, OP_NEG, 14, 1, 0, 0, 1, MINW));
    table_rows.push_back(mk(1, OP_EQ, 2, 2, 2, 0, 1, 64'd1));
    table_rows[21].cu = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (table_rows[i]) send_step(table_rows[i]);
    for (int n = 0; n < RANDOM_STEPS; n++) begin
      calm = (n >= 600 && n < 800);
      send_step(random_step());
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;
    wait (pending_writes.size() == 0);
    repeat (100) @(posedge clk);
    $display("Ran %0d steps (directed table and random programs), checked %0d results.",
             table_rows.size() + RANDOM_STEPS, checked);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
